// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file, ptc_checker.sv.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PTC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ptc_pkg.sv =====
// Shared types, constants and helper functions of the collision evaluator.
// Depends on nothing; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps
package ptc_pkg;

	localparam int CW       = 32;
	localparam int MARGIN_W = 31;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec3_t;

	typedef struct packed {
		coord_t particle_x;
		coord_t particle_y;
		coord_t particle_z;
		coord_t vertex_a_x;
		coord_t vertex_a_y;
		coord_t vertex_a_z;
		coord_t vertex_b_x;
		coord_t vertex_b_y;
		coord_t vertex_b_z;
		coord_t vertex_c_x;
		coord_t vertex_c_y;
		coord_t vertex_c_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] penetration;
		logic               degenerate;
	} out_word_t;

	typedef struct packed {
		vec3_t p;
		vec3_t a;
		vec3_t b;
		vec3_t c;
	} pts_t;

	typedef struct packed {
		vec3_t u;
		vec3_t v;
		vec3_t w;
	} edges_t;

	// Index 0 is x, 1 is y, 2 is z.
	typedef logic [2:0][63:0] v64_t;

	function automatic coord_t sat_sub(coord_t x, coord_t y);
		logic signed [CW:0] d;
		d = $signed({x[CW-1], x}) - $signed({y[CW-1], y});
		if (d[CW] != d[CW-1]) sat_sub = d[CW] ? COORD_MIN : COORD_MAX;
		else sat_sub = d[CW-1:0];
	endfunction

	function automatic vec3_t vsub(vec3_t x, vec3_t y);
		vsub.x = sat_sub(x.x, y.x);
		vsub.y = sat_sub(x.y, y.y);
		vsub.z = sat_sub(x.z, y.z);
	endfunction

	// Exact cross product of 32-bit vectors, wrapping at 64 bits.
	function automatic v64_t cross64(vec3_t a, vec3_t b);
		cross64[0] = 64'(a.y) * 64'(b.z) - 64'(a.z) * 64'(b.y);
		cross64[1] = 64'(a.z) * 64'(b.x) - 64'(a.x) * 64'(b.z);
		cross64[2] = 64'(a.x) * 64'(b.y) - 64'(a.y) * 64'(b.x);
	endfunction

endpackage

// ===== rtl/particle_triangle_collision_eval_core.sv =====
// Top level of the particle versus triangle collision evaluator.
// Depends on ptc_pkg, ptc_norm and ptc_plane.
`timescale 1ns / 1ps
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+------------------------------
//  in      | in  | in_valid / in_ready    | in_word_t: particle, A, B, C
//  out     | out | out_valid / out_ready  | out_word_t: penetration, flag
//  cfg     | in  | cfg_we                 | cfg_wdata: thickness margin
//
//  One word per cycle sustained while the skid register is empty. Each word
//  passes the front end, the face normalizer, the edge normalizers and the
//  plane terms in that order; each normalizer has a 32-stage square root and a
//  FRAC_BITS+1 stage divider. Reset clears all valid bits and the margin.
//  A stalled output word moves into a one-word skid register; the pipeline
//  holds while that register is full, so nothing is dropped or repeated.
//
module particle_triangle_collision_eval_core import ptc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [MARGIN_W-1:0]   cfg_wdata
);

	localparam int NW  = FRAC_BITS + 2;
	localparam int SB1 = $bits(pts_t) + $bits(edges_t);
	localparam int SB2 = $bits(pts_t) + 3*NW + 1;

	logic                en;
	logic [MARGIN_W-1:0] margin_q;

	// front end: capture, edges, face cross product
	logic   v_s1, v_s2, v_s3, v_s4;
	pts_t   pts_s1, pts_s2, pts_s3, pts_s4;
	edges_t edg_s2, edg_s3;
	v64_t   cr_s3;

	// face normalizer
	logic               n1_v, n1_nz;
	logic [2:0][NW-1:0] n1_n;
	logic [SB1-1:0]     n1_sb;
	pts_t               pts_n1;
	edges_t             edg_n1;
	vec3_t              n1_cv;

	// edge cross products
	v64_t               ec_s4 [3];
	logic [2:0][NW-1:0] nf_s4;
	logic               dg_s4;

	// edge normalizers
	logic               n2_v;
	logic [2:0][NW-1:0] t_n [3];
	logic [SB2-1:0]     n2_sb;
	pts_t               pts_n2;
	logic [2:0][NW-1:0] nf_n2;
	logic               dg_n2;

	// plane terms
	logic [2:0][NW-1:0] pl_n [4];
	vec3_t              pl_v [4];
	logic signed [31:0] term [4];
	logic v_p1, v_p2, v_p3;
	logic dg_p1, dg_p2, dg_p3;

	// result and skid
	logic signed [31:0] best;
	logic      vf_s;
	out_word_t out_s;
	logic      skid_v_q;
	out_word_t skid_q;

	// Advance everything unless a word waits in the skid register.
	assign en       = !skid_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) margin_q <= '0;
		else if (cfg_we) margin_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= n1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1   <= pts_t'(in_data);

			pts_s2   <= pts_s1;
			edg_s2.u <= vsub(pts_s1.b, pts_s1.a);
			edg_s2.v <= vsub(pts_s1.c, pts_s1.b);
			edg_s2.w <= vsub(pts_s1.a, pts_s1.c);

			pts_s3   <= pts_s2;
			edg_s3   <= edg_s2;
			cr_s3    <= cross64(edg_s2.u, edg_s2.v);
		end
	end

	ptc_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SBW(SB1)
	) u_norm_face (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(v_s3),
		.c_i(cr_s3),
		.sb_i({pts_s3, edg_s3}),
		.vld_o(n1_v),
		.n_o(n1_n),
		.nz_o(n1_nz),
		.sb_o(n1_sb)
	);

	assign {pts_n1, edg_n1} = n1_sb;

	// Sign-extend the face normal to coordinate width.
	always_comb begin
		n1_cv.x = coord_t'($signed(n1_n[0]));
		n1_cv.y = coord_t'($signed(n1_n[1]));
		n1_cv.z = coord_t'($signed(n1_n[2]));
	end

	// Edge normals are edge x face normal; a zero face normal gives zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			ec_s4[0] <= cross64(edg_n1.u, n1_cv);
			ec_s4[1] <= cross64(edg_n1.v, n1_cv);
			ec_s4[2] <= cross64(edg_n1.w, n1_cv);
			pts_s4   <= pts_n1;
			nf_s4    <= n1_n;
			dg_s4    <= !n1_nz;
		end
	end

	// Lane 0 carries the points, the face normal and the degenerate flag.
	ptc_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SBW(SB2)
	) u_norm_eu (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(v_s4),
		.c_i(ec_s4[0]),
		.sb_i({pts_s4, nf_s4, dg_s4}),
		.vld_o(n2_v),
		.n_o(t_n[0]),
		.nz_o(),
		.sb_o(n2_sb)
	);

	ptc_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SBW(1)
	) u_norm_ev (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(v_s4),
		.c_i(ec_s4[1]),
		.sb_i(1'b0),
		.vld_o(),
		.n_o(t_n[1]),
		.nz_o(),
		.sb_o()
	);

	ptc_norm #(
		.FRAC_BITS(FRAC_BITS),
		.SBW(1)
	) u_norm_ew (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(v_s4),
		.c_i(ec_s4[2]),
		.sb_i(1'b0),
		.vld_o(),
		.n_o(t_n[2]),
		.nz_o(),
		.sb_o()
	);

	assign {pts_n2, nf_n2, dg_n2} = n2_sb;

	// Face plane through A, edge planes through the start corner of each edge.
	always_comb begin
		pl_n[0] = nf_n2;
		pl_v[0] = pts_n2.a;
		pl_n[1] = t_n[0];
		pl_v[1] = pts_n2.a;
		pl_n[2] = t_n[1];
		pl_v[2] = pts_n2.b;
		pl_n[3] = t_n[2];
		pl_v[3] = pts_n2.c;
	end

	for (genvar g = 0; g < 4; g++) begin : g_plane
		ptc_plane #(
			.FRAC_BITS(FRAC_BITS)
		) u_plane (
			.clk(clk),
			.en(en),
			.n(pl_n[g]),
			.p(pts_n2.p),
			.v(pl_v[g]),
			.margin(margin_q),
			.term(term[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			vf_s <= 1'b0;
		end else if (en) begin
			v_p1 <= n2_v;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			vf_s <= v_p3;
		end
	end

	always_comb begin
		best = term[0];
		for (int g = 1; g < 4; g++) begin
			if (term[g] > best) best = term[g];
		end
	end

	// Degenerate triangles report zero penetration.
	always_ff @(posedge clk) begin
		if (en) begin
			dg_p1 <= dg_n2;
			dg_p2 <= dg_p1;
			dg_p3 <= dg_p2;
			out_s.penetration <= dg_p3 ? '0 : best;
			out_s.degenerate  <= dg_p3;
		end
	end

	// Park the last stage's word when the consumer stalls; drain when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_v_q <= 1'b0;
		else if (en && vf_s && !out_ready) skid_v_q <= 1'b1;
		else if (skid_v_q && out_ready) skid_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && vf_s && !out_ready) skid_q <= out_s;
	end

	assign out_valid = skid_v_q || vf_s;
	assign out_data  = skid_v_q ? skid_q : out_s;

endmodule

// ===== rtl/ptc_norm.sv =====
// Pipelined vector normalizer: range reduce, sum of squares, bit-per-stage
// square root and restoring divide. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_norm import ptc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SBW       = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  v64_t                          c_i,
	input  logic [SBW-1:0]                sb_i,
	output logic                          vld_o,
	output logic [2:0][FRAC_BITS+1:0]     n_o,
	output logic                          nz_o,
	output logic [SBW-1:0]                sb_o
);

	localparam int NW  = FRAC_BITS + 2;
	localparam int RW  = 30;
	localparam int DW  = FRAC_BITS + 32;
	localparam int SQ  = 32;
	localparam int DV  = FRAC_BITS + 1;
	localparam int MW  = SBW + 4;
	localparam int LW  = 31;
	localparam logic [5:0] MSB_LIM = 6'(RW - 1);

	// stage 1: magnitudes
	logic            v_s1;
	v64_t            mag_s1;
	logic [2:0]      neg_s1;
	logic [SBW-1:0]  sb_s1;
	// stage 2: largest magnitude
	logic            v_s2;
	logic [63:0]     mx_s2;
	v64_t            mag_s2;
	logic [2:0]      neg_s2;
	logic [SBW-1:0]  sb_s2;
	// stage 3: shift amount
	logic            v_s3;
	logic [5:0]      shf_s3;
	logic            nz_s3;
	v64_t            mag_s3;
	logic [2:0]      neg_s3;
	logic [SBW-1:0]  sb_s3;
	// stage 4: reduced components
	logic                 v_s4;
	logic [2:0][RW-1:0]   r_s4;
	logic [MW-1:0]        mt_s4;
	// stage 5: squares
	logic                 v_s5;
	logic [2*RW-1:0]      sq_s5 [3];
	logic [2:0][RW-1:0]   r_s5;
	logic [MW-1:0]        mt_s5;

	logic [63:0] mx_c;
	logic [5:0]  msb_c;
	logic [5:0]  shf_c;

	// square root stages, index 0 holds the sum of squares
	logic                 sv_s [0:SQ];
	logic [63:0]          sx_s [0:SQ];
	logic [63:0]          sr_s [0:SQ];
	logic [2:0][RW-1:0]   rr_s [0:SQ];
	logic [MW-1:0]        mt_s [0:SQ];

	// divide stages, index 0 holds the shifted dividends
	logic                 dv_s [0:DV];
	logic [2:0][DW-1:0]   dr_s [0:DV];
	logic [2:0][DV-1:0]   dq_s [0:DV];
	logic [LW-1:0]        dl_s [0:DV];
	logic [MW-1:0]        dm_s [0:DV];

	logic                 v_so;
	logic [2:0][NW-1:0]   n_so;
	logic                 nz_so;
	logic [SBW-1:0]       sb_so;

	always_comb begin
		mx_c = mag_s1[0];
		if (mag_s1[1] > mx_c) mx_c = mag_s1[1];
		if (mag_s1[2] > mx_c) mx_c = mag_s1[2];
	end

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (mx_s2[i]) msb_c = 6'(i);
		end
		shf_c = (msb_c > MSB_LIM) ? msb_c - MSB_LIM : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sv_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sv_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= c_i[k][63];
				mag_s1[k] <= c_i[k][63] ? 64'd0 - c_i[k] : c_i[k];
			end
			sb_s1  <= sb_i;

			mx_s2  <= mx_c;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;

			shf_s3 <= shf_c;
			nz_s3  <= mx_s2 != '0;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sb_s3  <= sb_s2;

			for (int k = 0; k < 3; k++) begin
				r_s4[k] <= RW'(mag_s3[k] >> shf_s3);
			end
			mt_s4 <= {sb_s3, nz_s3, neg_s3};

			for (int k = 0; k < 3; k++) begin
				sq_s5[k] <= (2*RW)'(r_s4[k]) * (2*RW)'(r_s4[k]);
			end
			r_s5  <= r_s4;
			mt_s5 <= mt_s4;

			sx_s[0] <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]);
			sr_s[0] <= '0;
			rr_s[0] <= r_s5;
			mt_s[0] <= mt_s5;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'(1) << (62 - 2*k);
		logic [63:0] trial;
		logic        take;
		assign trial = sr_s[k] + BIT;
		assign take  = sx_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_s[k+1] <= 1'b0;
			else if (en) sv_s[k+1] <= sv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[k+1] <= take ? sx_s[k] - trial : sx_s[k];
				sr_s[k+1] <= take ? (sr_s[k] >> 1) + BIT : sr_s[k] >> 1;
				rr_s[k+1] <= rr_s[k];
				mt_s[k+1] <= mt_s[k];
			end
		end
	end

	// Load dividends; a zero vector divides by one and is masked at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (en) dv_s[0] <= sv_s[SQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dr_s[0][k] <= DW'(rr_s[SQ][k]) << FRAC_BITS;
			end
			dq_s[0] <= '0;
			dl_s[0] <= mt_s[SQ][3] ? sr_s[SQ][LW-1:0] : LW'(1);
			dm_s[0] <= mt_s[SQ];
		end
	end

	for (genvar j = 0; j < DV; j++) begin : g_div
		localparam int SH = FRAC_BITS - j;
		logic [DW-1:0] dsr;
		assign dsr = DW'(dl_s[j]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[j+1] <= 1'b0;
			else if (en) dv_s[j+1] <= dv_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					if (dr_s[j][k] >= dsr) begin
						dr_s[j+1][k] <= dr_s[j][k] - dsr;
						dq_s[j+1][k] <= dq_s[j][k] | (DV'(1) << SH);
					end else begin
						dr_s[j+1][k] <= dr_s[j][k];
						dq_s[j+1][k] <= dq_s[j][k];
					end
				end
				dl_s[j+1] <= dl_s[j];
				dm_s[j+1] <= dm_s[j];
			end
		end
	end

	// Restore signs, drop the result of a zero vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_so <= 1'b0;
		else if (en) v_so <= dv_s[DV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (!dm_s[DV][3]) n_so[k] <= '0;
				else if (dm_s[DV][k]) n_so[k] <= NW'(0) - NW'(dq_s[DV][k]);
				else n_so[k] <= NW'(dq_s[DV][k]);
			end
			nz_so <= dm_s[DV][3];
			sb_so <= dm_s[DV][MW-1:4];
		end
	end

	assign vld_o = v_so;
	assign n_o   = n_so;
	assign nz_o  = nz_so;
	assign sb_o  = sb_so;

endmodule

// ===== rtl/ptc_plane.sv =====
// One plane term: dot product against the particle offset, scale back,
// subtract margin, clamp and saturate. Three stages. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_plane import ptc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2:0][FRAC_BITS+1:0]  n,
	input  vec3_t                      p,
	input  vec3_t                      v,
	input  logic [MARGIN_W-1:0]        margin,
	output logic signed [31:0]         term
);

	localparam int NW = FRAC_BITS + 2;
	localparam int PW = NW + CW + 1;
	localparam logic signed [65:0] LOWER = -66'sd2147483648;

	logic signed [CW:0]   d_c [3];
	logic signed [PW-1:0] prod_c [3];
	logic signed [PW-1:0] prod_s1 [3];
	logic signed [63:0]   sum_s2;
	logic signed [31:0]   term_s3;

	logic        sneg;
	logic [63:0] amag;
	logic [63:0] ashr;
	logic signed [65:0] dl;
	logic signed [31:0] res;

	always_comb begin
		d_c[0] = $signed({p.x[CW-1], p.x}) - $signed({v.x[CW-1], v.x});
		d_c[1] = $signed({p.y[CW-1], p.y}) - $signed({v.y[CW-1], v.y});
		d_c[2] = $signed({p.z[CW-1], p.z}) - $signed({v.z[CW-1], v.z});
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = $signed(n[k]) * d_c[k];
		end
	end

	always_comb begin
		sneg = sum_s2[63];
		amag = sneg ? 64'd0 - sum_s2 : sum_s2;
		ashr = amag >> FRAC_BITS;
		dl   = sneg ? -$signed({2'b00, ashr}) : $signed({2'b00, ashr});
		dl   = dl - $signed({35'd0, margin});
		if (dl > 66'sd0) res = '0;
		else if (dl < LOWER) res = COORD_MIN;
		else res = dl[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			sum_s2  <= 64'(prod_s1[0]) + 64'(prod_s1[1]) + 64'(prod_s1[2]);
			term_s3 <= res;
		end
	end

	assign term = term_s3;

endmodule

// ===== rtl/ptc_checker.sv =====
// Port-level checks of the collision evaluator and the bind that attaches them.
// Depends on ptc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptc_checker import ptc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	logic in_seen;
	assign in_seen = in_valid && in_ready && (in_data.particle_x == in_data.particle_x);

	`PTC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "out word dropped")
	`PTC_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_data), "out word changed")
	`PTC_NEVER(a_degen_zero, clk, arst_n, out_valid && out_data.degenerate && out_data.penetration != 0, "degenerate with nonzero value")
	`PTC_NEVER(a_positive, clk, arst_n, out_valid && !out_data.penetration[31] && out_data.penetration != 0, "positive penetration")
	`PTC_ASSERT(a_ready_stall, clk, arst_n, !in_ready |-> out_valid && !in_seen, "input stalled with no waiting word")

endmodule

bind particle_triangle_collision_eval_core ptc_checker u_ptc_checker (.*);

// ===== test/testbench.sv =====
// Testbench of particle_triangle_collision_eval_core: drives collision pairs,
// predicts each penetration word and compares every output word in order.
// Depends on ptc_pkg and the RTL of the collision evaluator.
`timescale 1ns / 1ps
module testbench;
	import ptc_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 2 * FB + 90;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_data;
	logic cfg_we = 0;
	logic [MARGIN_W-1:0] cfg_wdata = '0;

	// Margin copy used by the predictor.
	logic [MARGIN_W-1:0] margin_q = '0;
	// Penetration words still owed by the block, oldest first.
	out_word_t penetration_q[$];
	int fail_count = 0;
	longint cycle_count = 0;
	// Idle odds in percent for sender and receiver.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// Cycles left in a long receiver hold-off.
	int recv_hold = 0;

	particle_triangle_collision_eval_core #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor arithmetic. Values are held in 64 bits; every product fits.
	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint shr_trunc(longint v, int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = longint'(unsigned'(m) >> s);
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3],
			output longint c[3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Scale to a unit vector in Q1.FB; zero stays zero.
	function automatic bit to_unit(input longint c[3], output longint n[3]);
		longint unsigned m, sum, len, q, mi;
		longint r[3];
		int s;
		m = 0;
		sum = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			mi = (c[i] < 0) ? -c[i] : c[i];
			if (mi > m) m = mi;
		end
		if (m == 0) begin
			n = '{0, 0, 0};
			return 0;
		end
		while ((m >> s) >= (64'd1 << 30)) s++;
		for (int i = 0; i < 3; i++) begin
			r[i] = shr_trunc(c[i], s);
			mi = (r[i] < 0) ? -r[i] : r[i];
			sum += mi * mi;
		end
		len = root64(sum);
		for (int i = 0; i < 3; i++) begin
			mi = (r[i] < 0) ? -r[i] : r[i];
			q = (mi << FB) / len;
			n[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint plane_depth(input longint n[3], input longint p[3],
			input longint v[3]);
		longint a, d;
		a = (n[0] * p[0] + n[1] * p[1] + n[2] * p[2])
			- (n[0] * v[0] + n[1] * v[1] + n[2] * v[2]);
		d = shr_trunc(a, FB) - longint'(margin_q);
		if (d > 0) d = 0;
		return sat32(d);
	endfunction

	function automatic out_word_t predict_penetration(in_word_t w);
		longint p[3], a[3], b[3], c[3], u[3], v[3], e[3], cr[3], n[3], t[3];
		longint best, d;
		out_word_t o;
		p = '{w.particle_x, w.particle_y, w.particle_z};
		a = '{w.vertex_a_x, w.vertex_a_y, w.vertex_a_z};
		b = '{w.vertex_b_x, w.vertex_b_y, w.vertex_b_z};
		c = '{w.vertex_c_x, w.vertex_c_y, w.vertex_c_z};
		for (int i = 0; i < 3; i++) begin
			u[i] = sat32(b[i] - a[i]);
			v[i] = sat32(c[i] - b[i]);
			e[i] = sat32(a[i] - c[i]);
		end
		cross3(u, v, cr);
		o = '0;
		if (!to_unit(cr, n)) begin
			o.degenerate = 1'b1;
			return o;
		end
		best = plane_depth(n, p, a);
		cross3(u, n, cr);
		void'(to_unit(cr, t));
		d = plane_depth(t, p, a);
		if (d > best) best = d;
		cross3(v, n, cr);
		void'(to_unit(cr, t));
		d = plane_depth(t, p, b);
		if (d > best) best = d;
		cross3(e, n, cr);
		void'(to_unit(cr, t));
		d = plane_depth(t, p, c);
		if (d > best) best = d;
		o.penetration = best[31:0];
		return o;
	endfunction

	// Cycle counter; stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Compare each accepted output word with the oldest prediction.
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (penetration_q.size() == 0) begin
				$display("%0t unexpected word %h", $time, out_data);
				fail_count++;
			end else begin
				exp_w = penetration_q.pop_front();
				if (out_data.penetration !== exp_w.penetration) begin
					$display("%0t penetration expected %0d actual %0d", $time,
						exp_w.penetration, out_data.penetration);
					fail_count++;
				end
				if (out_data.degenerate !== exp_w.degenerate) begin
					$display("%0t degenerate expected %0b actual %0b", $time,
						exp_w.degenerate, out_data.degenerate);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random idling, or a long hold-off while the pipe fills.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Send one word: hold valid and payload until accepted. Valid stays high
	// after the accepting edge; the next idle cycle or the caller drops it.
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		penetration_q = {penetration_q, predict_penetration(w)};
		@(negedge clk);
	endtask

	// Drain all predictions, then let the pipe settle before a margin write.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (penetration_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] m);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		margin_q = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'($urandom());
			1: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
			2: return coord_t'($signed($urandom_range(65535)) - 32768) <<< 8;
			default: return coord_t'($signed($urandom_range(2 * 65536 * 40))
				- 65536 * 40);
		endcase
	endfunction

	// Particle near a random triangle so it lands inside the prism often.
	function automatic in_word_t rand_pair();
		in_word_t w;
		coord_t sx, sy, sz;
		int f;
		w = in_word_t'({$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom()});
		f = $urandom_range(9);
		if (f < 7) begin
			w.vertex_a_x = rand_coord();
			w.vertex_a_y = rand_coord();
			w.vertex_a_z = rand_coord();
			w.vertex_b_x = rand_coord();
			w.vertex_b_y = rand_coord();
			w.vertex_b_z = rand_coord();
			w.vertex_c_x = rand_coord();
			w.vertex_c_y = rand_coord();
			w.vertex_c_z = rand_coord();
			// Three quarters of the centroid plus a small offset.
			sx = (w.vertex_a_x >>> 2) + (w.vertex_b_x >>> 2) + (w.vertex_c_x >>> 2);
			sy = (w.vertex_a_y >>> 2) + (w.vertex_b_y >>> 2) + (w.vertex_c_y >>> 2);
			sz = (w.vertex_a_z >>> 2) + (w.vertex_b_z >>> 2) + (w.vertex_c_z >>> 2);
			w.particle_x = sx + coord_t'($signed($urandom_range(131072)) - 65536);
			w.particle_y = sy + coord_t'($signed($urandom_range(131072)) - 65536);
			w.particle_z = sz + coord_t'($signed($urandom_range(131072)) - 65536);
		end else if (f == 7) begin
			// A repeated corner (B equal to A) makes a degenerate face.
			w.vertex_b_x = w.vertex_a_x;
			w.vertex_b_y = w.vertex_a_y;
			w.vertex_b_z = w.vertex_a_z;
		end
		return w;
	endfunction

	function automatic in_word_t make_pair(coord_t px, coord_t py, coord_t pz,
			coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by, coord_t bz,
			coord_t cx, coord_t cy, coord_t cz);
		return '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
	endfunction

	task automatic test_directed();
		coord_t one;
		one = 32'sd65536;
		send_word(make_pair(one/4, one/4, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
		send_word(make_pair(one/4, one/4, -one/8, 0, 0, 0, one, 0, 0, 0, one, 0));
		send_word(make_pair(3*one, 3*one, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
		// Degenerate: repeated corner and collinear corners.
		send_word(make_pair(0, 0, 0, one, one, one, one, one, one, 0, 0, 0));
		send_word(make_pair(one, 0, 0, 0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
		send_word('0);
		// Huge coordinates saturate edges and plane terms.
		send_word(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_word(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0,
			COORD_MAX, 0, 0, 0, COORD_MAX, 0));
		send_word(make_pair(0, 0, 0, COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0,
			0, COORD_MAX, 0));
		send_word('1);
		send_word(make_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0));
		send_word(make_pair(1, -1, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0));
		// Tiny triangle: edge normals may round to zero.
		send_word(make_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1));
	endtask

	task automatic test_margin_sweep();
		write_margin('1);
		test_directed();
		write_margin(31'd65536);
		test_directed();
		write_margin(31'd1 << 30);
		repeat (5) send_word(rand_pair());
	endtask

	task automatic test_random_phase(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_word(rand_pair());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid <= 1'b0;
		// Hold the receiver off long enough that the block fills and stalls input.
		@(negedge clk);
		recv_hold <= 3 * LATENCY;
		repeat (2 * LATENCY) send_word(rand_pair());
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_margin_sweep();
		write_margin(31'd0);
		test_random_phase(600, 20, 82);
		write_margin(31'($urandom_range(65536 * 4)));
		test_random_phase(600, 82, 20);
		write_margin(31'($urandom()));
		test_random_phase(350, 0, 0);
		test_backpressure();
		drain_pipe();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
